// ----- rtl/u8u16_pkg.sv -----
// Package for the UTF-8 to UTF-16 decoder core.
// Holds the queue entry type, its kind codes and the fixed field widths.
// No dependencies.
package u8u16_pkg;

   localparam int BYTE_W   = 8;
   localparam int UNIT_W   = 16;
   localparam int SCALAR_W = 21;
   localparam int TOTAL_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_UNIT  = 2'd1;
   localparam logic [1:0] KIND_PAIR  = 2'd2;
   localparam logic [1:0] KIND_ERROR = 2'd3;

   localparam logic [SCALAR_W-1:0] MIN_TWO_BYTE   = 21'h00080;
   localparam logic [SCALAR_W-1:0] MIN_THREE_BYTE = 21'h00800;
   localparam logic [SCALAR_W-1:0] MIN_FOUR_BYTE  = 21'h10000;
   localparam logic [SCALAR_W-1:0] MAX_SCALAR     = 21'h10FFFF;
   localparam logic [SCALAR_W-1:0] SURR_FIRST     = 21'h0D800;
   localparam logic [SCALAR_W-1:0] SURR_END       = 21'h0E000;
   localparam logic [UNIT_W-1:0]   HIGH_SURR_BASE = 16'hD800;
   localparam logic [UNIT_W-1:0]   LOW_SURR_BASE  = 16'hDC00;

   typedef struct packed {
      logic [1:0]          kind;
      logic [SCALAR_W-1:0] scalar;
      logic                done;
      logic [TOTAL_W-1:0]  total_first;
      logic [TOTAL_W-1:0]  total_second;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

// ----- rtl/u8u16_req_if.sv -----
// Request channel of the UTF-8 to UTF-16 decoder: one UTF-8 byte per transaction.
// Depends on nothing.
interface u8u16_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       last_byte;

   modport source (output valid, output in_byte, output last_byte, input ready);
   modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- rtl/u8u16_rsp_if.sv -----
// Response channel of the UTF-8 to UTF-16 decoder: one UTF-16 unit per transaction.
// Depends on nothing.
interface u8u16_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] code_unit;
   logic        is_error;
   logic        run_last;
   logic        string_done;
   logic [15:0] unit_total;

   modport source (output valid, output code_unit, output is_error, output run_last,
                   output string_done, output unit_total, input ready);
   modport sink   (input valid, input code_unit, input is_error, input run_last,
                   input string_done, input unit_total, output ready);
endinterface

// ----- rtl/u8u16_front.sv -----
// Front end: byte classification, sequence assembly, validity checks and unit count.
// Pushes one queue entry per byte that yields results. Depends on u8u16_pkg.
module u8u16_front #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             in_byte,
   input  logic                   last_byte,
   output logic                   push,
   output u8u16_pkg::entry_type   push_entry
);

   logic [u8u16_pkg::SCALAR_W-1:0] partial_ff, partial_in;
   logic [1:0]                     remaining_ff, remaining_in;
   logic [1:0]                     length_ff, length_in;
   logic                           error_ff, error_in;
   logic [COUNT_WIDTH-1:0]         count_ff, count_in;

   logic [COUNT_WIDTH-1:0]         count_one, count_two;
   logic [u8u16_pkg::SCALAR_W-1:0] gathered;
   logic [1:0]                     kind;
   logic [u8u16_pkg::SCALAR_W-1:0] scalar;

   assign count_one = (count_ff == {COUNT_WIDTH{1'b1}}) ? count_ff
                      : COUNT_WIDTH'(count_ff + 1'b1);
   assign count_two = (count_one == {COUNT_WIDTH{1'b1}}) ? count_one
                      : COUNT_WIDTH'(count_one + 1'b1);
   assign gathered  = {partial_ff[u8u16_pkg::SCALAR_W-7:0], in_byte[5:0]};

   always_comb begin
      partial_in   = partial_ff;
      remaining_in = remaining_ff;
      length_in    = length_ff;
      error_in     = error_ff;
      count_in     = count_ff;
      kind         = u8u16_pkg::KIND_NONE;
      scalar       = '0;

      if (!error_ff) begin
         if (remaining_ff == 2'd0) begin
            priority if (in_byte[7] == 1'b0) begin
               kind   = u8u16_pkg::KIND_UNIT;
               scalar = {13'd0, in_byte};
            end else if (in_byte[7:6] == 2'b10) begin
               error_in = 1'b1;
            end else if (in_byte[7:5] == 3'b110) begin
               partial_in   = {16'd0, in_byte[4:0]};
               remaining_in = 2'd1;
               length_in    = 2'd1;
            end else if (in_byte[7:4] == 4'b1110) begin
               partial_in   = {17'd0, in_byte[3:0]};
               remaining_in = 2'd2;
               length_in    = 2'd2;
            end else if (in_byte[7:3] == 5'b11110) begin
               partial_in   = {18'd0, in_byte[2:0]};
               remaining_in = 2'd3;
               length_in    = 2'd3;
            end else begin
               error_in = 1'b1;
            end
         end else if (in_byte[7:6] != 2'b10) begin
            error_in = 1'b1;
         end else begin
            partial_in   = gathered;
            remaining_in = remaining_ff - 2'd1;
            if (remaining_ff == 2'd1) begin
               scalar = gathered;
               unique case (length_ff)
                  2'd1: begin
                     if (gathered < u8u16_pkg::MIN_TWO_BYTE) error_in = 1'b1;
                     else kind = u8u16_pkg::KIND_UNIT;
                  end
                  2'd2: begin
                     if (gathered < u8u16_pkg::MIN_THREE_BYTE ||
                         (gathered >= u8u16_pkg::SURR_FIRST &&
                          gathered < u8u16_pkg::SURR_END)) error_in = 1'b1;
                     else kind = u8u16_pkg::KIND_UNIT;
                  end
                  default: begin
                     if (gathered < u8u16_pkg::MIN_FOUR_BYTE ||
                         gathered > u8u16_pkg::MAX_SCALAR) error_in = 1'b1;
                     else kind = u8u16_pkg::KIND_PAIR;
                  end
               endcase
               partial_in = '0;
               length_in  = 2'd0;
            end
         end
      end

      unique case (kind)
         u8u16_pkg::KIND_UNIT: count_in = count_one;
         u8u16_pkg::KIND_PAIR: count_in = count_two;
         default:              count_in = count_ff;
      endcase

      push_entry.kind         = kind;
      push_entry.scalar       = scalar;
      push_entry.done         = 1'b0;
      push_entry.total_first  = u8u16_pkg::TOTAL_W'(count_one);
      push_entry.total_second = u8u16_pkg::TOTAL_W'(count_two);

      if (last_byte) begin
         if (remaining_in != 2'd0) error_in = 1'b1;
         if (error_in) begin
            push_entry.kind         = u8u16_pkg::KIND_ERROR;
            push_entry.scalar       = '0;
            push_entry.total_first  = u8u16_pkg::TOTAL_W'(count_ff);
            push_entry.total_second = u8u16_pkg::TOTAL_W'(count_ff);
         end
         push_entry.done = 1'b1;
         partial_in   = '0;
         remaining_in = 2'd0;
         length_in    = 2'd0;
         error_in     = 1'b0;
         count_in     = '0;
      end else if (error_in) begin
         partial_in   = '0;
         remaining_in = 2'd0;
         length_in    = 2'd0;
      end

      push = accept && (last_byte || kind != u8u16_pkg::KIND_NONE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         remaining_ff <= 2'd0;
         length_ff    <= 2'd0;
         error_ff     <= 1'b0;
         count_ff     <= '0;
      end else if (accept) begin
         partial_ff   <= partial_in;
         remaining_ff <= remaining_in;
         length_ff    <= length_in;
         error_ff     <= error_in;
         count_ff     <= count_in;
      end
   end

endmodule

// ----- rtl/u8u16_queue.sv -----
// Two-entry queue between front and back end of the decoder.
// Depends on u8u16_pkg.
module u8u16_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  u8u16_pkg::entry_type push_entry,
   input  logic                 pop,
   output logic                 full,
   output u8u16_pkg::head_type  head
);

   u8u16_pkg::entry_type slot_ff [u8u16_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       do_push, do_pop;

   assign full       = (fill_ff == 2'(u8u16_pkg::QUEUE_DEPTH));
   assign do_push    = push && !full;
   assign do_pop     = pop && (fill_ff != 2'd0);
   assign head.valid = (fill_ff != 2'd0);
   assign head.entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + 2'd1;
      if (!do_push && do_pop) fill_in = fill_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- rtl/u8u16_back.sv -----
// Back end: expands queue entries into UTF-16 units, splits surrogate pairs,
// and holds the registered response. Depends on u8u16_pkg and u8u16_rsp_if.
module u8u16_back (
   input  logic                clock,
   input  logic                reset,
   input  u8u16_pkg::head_type head,
   output logic                pop,
   u8u16_rsp_if.source         rsp_chan
);

   logic        valid_ff, valid_in;
   logic        half_ff, half_in;
   logic [15:0] unit_ff, unit_in;
   logic        error_ff, error_in;
   logic        run_last_ff, run_last_in;
   logic        done_ff, done_in;
   logic [15:0] total_ff, total_in;

   logic        load;
   logic [20:0] offset;

   assign load   = !valid_ff || rsp_chan.ready;
   assign offset = head.entry.scalar - u8u16_pkg::MIN_FOUR_BYTE;

   always_comb begin
      valid_in    = valid_ff;
      half_in     = half_ff;
      unit_in     = unit_ff;
      error_in    = error_ff;
      run_last_in = run_last_ff;
      done_in     = done_ff;
      total_in    = total_ff;
      pop         = 1'b0;
      if (load) begin
         valid_in = head.valid;
         if (head.valid) begin
            error_in    = 1'b0;
            run_last_in = 1'b1;
            done_in     = head.entry.done;
            total_in    = head.entry.total_first;
            unique case (head.entry.kind)
               u8u16_pkg::KIND_PAIR: begin
                  if (!half_ff) begin
                     unit_in     = u8u16_pkg::HIGH_SURR_BASE | {6'd0, offset[19:10]};
                     run_last_in = 1'b0;
                     done_in     = 1'b0;
                     half_in     = 1'b1;
                  end else begin
                     unit_in  = u8u16_pkg::LOW_SURR_BASE | {6'd0, offset[9:0]};
                     total_in = head.entry.total_second;
                     half_in  = 1'b0;
                     pop      = 1'b1;
                  end
               end
               u8u16_pkg::KIND_ERROR: begin
                  unit_in  = '0;
                  error_in = 1'b1;
                  pop      = 1'b1;
               end
               default: begin
                  unit_in = head.entry.scalar[15:0];
                  pop     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      unit_ff     <= unit_in;
      error_ff    <= error_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
      total_ff    <= total_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.code_unit   = unit_ff;
   assign rsp_chan.is_error    = error_ff;
   assign rsp_chan.run_last    = run_last_ff;
   assign rsp_chan.string_done = done_ff;
   assign rsp_chan.unit_total  = total_ff;

endmodule

// ----- rtl/utf8_to_utf16_decoder_core.sv -----
// UTF-8 to UTF-16 decoder core: top level.
// Depends on u8u16_pkg, u8u16_req_if, u8u16_rsp_if, u8u16_front, u8u16_queue, u8u16_back.
//
// Usage:
//   req_chan carries one UTF-8 byte per transaction, with last_byte marking the
//   end of a string. rsp_chan carries one UTF-16 unit per transaction, with
//   is_error, run_last, string_done and the running unit_total.
//   The front end accepts one byte per cycle while the queue is not full. Each
//   result is registered in a queue entry and then in the response register.
//   The back end sends one unit per cycle while rsp_chan is ready, so a
//   four-byte sequence (surrogate pair) holds it for both units; the queue then
//   fills and req_chan.ready drops for one cycle when the next byte that yields
//   a transaction follows at once. Malformed strings give no units after the
//   fault; the last byte then gives one error transaction. Every string ends
//   with a transaction that has string_done set.
//   When rsp_chan stalls, the response register holds and the queue fills;
//   req_chan.ready drops once both queue entries are in use.
//   Synchronous reset clears the decoding state, the queue and the response
//   valid and holds req_chan.ready low; the first byte may be taken in the
//   cycle after reset falls.
module utf8_to_utf16_decoder_core #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   u8u16_req_if.sink   req_chan,
   u8u16_rsp_if.source rsp_chan
);

   logic                 full;
   logic                 accept;
   logic                 push;
   logic                 pop;
   u8u16_pkg::entry_type push_entry;
   u8u16_pkg::head_type  head;

   assign req_chan.ready = !full && !reset;
   assign accept         = req_chan.valid && req_chan.ready;

   u8u16_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .in_byte    (req_chan.in_byte),
      .last_byte  (req_chan.last_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   u8u16_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .head       (head)
   );

   u8u16_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

// ----- rtl/u8u16_checker.sv -----
// Port-level checks for the UTF-8 to UTF-16 decoder core, bound to the top level.
// Depends on utf8_to_utf16_decoder_core.
module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] code_unit,
   input logic        is_error,
   input logic        run_last,
   input logic        string_done,
   input logic [15:0] unit_total
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_error |-> code_unit == 16'd0 && run_last && string_done)
      else $error("malformed error transaction");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !run_last |-> code_unit[15:10] == 6'b110110 && !is_error && !string_done)
      else $error("non-final unit is not a high surrogate");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(code_unit) && $stable(is_error)
         && $stable(run_last) && $stable(string_done) && $stable(unit_total))
      else $error("stalled response changed");

endmodule

bind utf8_to_utf16_decoder_core u8u16_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .code_unit   (rsp_chan.code_unit),
   .is_error    (rsp_chan.is_error),
   .run_last    (rsp_chan.run_last),
   .string_done (rsp_chan.string_done),
   .unit_total  (rsp_chan.unit_total)
);
